// File: rtl/lsd_pkg.sv
// Shared types and constants for the LZSS stream decoder.
// Used by every module under rtl/; depends on nothing else.
package lsd_pkg;

  // Config and header widths
  localparam int unsigned POS_W    = 12;
  localparam int unsigned BUDGET_W = 17;

  localparam logic [POS_W-1:0] START_POS_RST = 12'hFEE;
  localparam logic [7:0]       FLAG_MSB      = 8'h80;

  // Command queue between front and back
  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CW    = $clog2(CQ_DEPTH + 1);

  // Result queue at the output
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  // One input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       block_end;
  } out_item_t;

  // Parser phase of the front part
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HDR_LO,
    PH_DATA,
    PH_TOK_LO
  } front_phase_t;

  // Back part sequencer
  typedef enum logic {
    B_IDLE,
    B_COPY
  } back_state_t;

  // Command codes passed from front to back
  typedef enum logic [1:0] {
    CMD_START,
    CMD_LIT,
    CMD_COPY
  } cmd_kind_t;

  // Command: arg is start position, literal byte (low bits) or match source
  typedef struct packed {
    cmd_kind_t        kind;
    logic [POS_W-1:0] arg;
    logic [3:0]       len_code;
    logic             last_blk;
  } cmd_t;

endpackage

// File: rtl/lsd_front.sv
// Front part: parses header, flag bytes and tokens into window commands.
// Depends on lsd_pkg.
module lsd_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  lsd_pkg::in_item_t       in_item,
  input  logic [lsd_pkg::POS_W-1:0] start_pos,
  output logic                    cmd_push,
  output lsd_pkg::cmd_t           cmd
);
  import lsd_pkg::*;

  front_phase_t        ph, ph_next;
  logic [BUDGET_W-1:0] budget;
  logic [7:0]          flag_bits;
  logic [7:0]          flag_mask;
  logic [7:0]          tok_hi;

  logic [BUDGET_W-1:0] bud_m1, bud_m2;
  logic                end1, end2;
  logic                is_flag, is_lit;
  logic [7:0]          b;

  // Budget after a one- or two-unit charge, saturating at zero
  always_comb begin
    b       = in_item.in_byte;
    bud_m1  = (budget > BUDGET_W'(1)) ? budget - BUDGET_W'(1) : '0;
    bud_m2  = (budget > BUDGET_W'(2)) ? budget - BUDGET_W'(2) : '0;
    end1    = (bud_m1 == '0);
    end2    = (bud_m2 == '0);
    is_flag = (flag_mask == 8'h00);
    is_lit  = (flag_bits & flag_mask) != 8'h00;
  end

  // Next phase
  always_comb begin
    ph_next = ph;
    if (accept) begin
      if (in_item.start_req) begin
        ph_next = PH_HDR_LO;
      end else begin
        unique case (ph)
          PH_IDLE:   ph_next = PH_IDLE;
          PH_HDR_LO: ph_next = PH_DATA;
          PH_DATA: begin
            if (is_flag) ph_next = PH_DATA;
            else if (is_lit) ph_next = end1 ? PH_IDLE : PH_DATA;
            else ph_next = PH_TOK_LO;
          end
          PH_TOK_LO: ph_next = end2 ? PH_IDLE : PH_DATA;
          default:   ph_next = PH_IDLE;
        endcase
      end
    end
  end

  // Command generation
  always_comb begin
    cmd_push     = 1'b0;
    cmd.kind     = CMD_LIT;
    cmd.arg      = {4'h0, b};
    cmd.len_code = b[3:0];
    cmd.last_blk = 1'b0;
    if (accept) begin
      if (in_item.start_req) begin
        cmd_push = 1'b1;
        cmd.kind = CMD_START;
        cmd.arg  = start_pos;
      end else begin
        unique case (ph) inside
          PH_IDLE, PH_HDR_LO: cmd_push = 1'b0;
          PH_DATA: begin
            if (!is_flag && is_lit) begin
              cmd_push     = 1'b1;
              cmd.kind     = CMD_LIT;
              cmd.last_blk = end1;
            end
          end
          PH_TOK_LO: begin
            cmd_push     = 1'b1;
            cmd.kind     = CMD_COPY;
            cmd.arg      = {tok_hi, b[7:4]};
            cmd.last_blk = end2;
          end
          default: cmd_push = 1'b0;
        endcase
      end
    end
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) ph <= PH_IDLE;
    else ph <= ph_next;
  end

  // Parser datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      budget    <= '0;
      flag_bits <= '0;
      flag_mask <= '0;
      tok_hi    <= '0;
    end else if (accept) begin
      if (in_item.start_req) begin
        budget    <= {1'b0, b, 8'h00};
        flag_bits <= '0;
        flag_mask <= '0;
        tok_hi    <= '0;
      end else begin
        unique case (ph)
          PH_IDLE: tok_hi <= tok_hi;
          PH_HDR_LO: budget <= {1'b0, budget[15:8], b} + BUDGET_W'(1);
          PH_DATA: begin
            if (is_flag) begin
              flag_bits <= b;
              flag_mask <= FLAG_MSB;
              budget    <= bud_m1;
            end else if (is_lit) begin
              budget    <= bud_m1;
              flag_mask <= flag_mask >> 1;
            end else begin
              tok_hi <= b;
            end
          end
          PH_TOK_LO: begin
            budget    <= bud_m2;
            flag_mask <= flag_mask >> 1;
          end
          default: tok_hi <= tok_hi;
        endcase
      end
    end
  end

endmodule

// File: rtl/lsd_cmd_queue.sv
// Short command queue decoupling the parser from the window engine.
// Depends on lsd_pkg.
module lsd_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lsd_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output lsd_pkg::cmd_t rd_cmd,
  output logic          empty
);
  import lsd_pkg::*;

  cmd_t             slots [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr, rd_ptr;
  logic [CQ_CW-1:0] cnt;
  logic             do_wr, do_rd;

  // Status and head
  always_comb begin
    full   = (cnt == CQ_CW'(CQ_DEPTH));
    empty  = (cnt == '0);
    do_wr  = wr_en && !full;
    do_rd  = rd_en && !empty;
    rd_cmd = slots[rd_ptr];
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + CQ_AW'(1);
      if (do_rd) rd_ptr <= rd_ptr + CQ_AW'(1);
      cnt <= cnt + CQ_CW'(do_wr) - CQ_CW'(do_rd);
    end
  end

endmodule

// File: rtl/lsd_back.sv
// Back part: history window, literal store and match copy engine, result queue.
// Depends on lsd_pkg.
module lsd_back #(
  parameter int unsigned WINDOW_SIZE = 4096,
  parameter int unsigned MIN_MATCH   = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  lsd_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output lsd_pkg::out_item_t out_item,
  output logic               empty,
  input  logic               pop
);
  import lsd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam int unsigned LW = $clog2(15 + MIN_MATCH + 1);
  localparam logic [AW:0] WIN_FULL = (AW + 1)'(WINDOW_SIZE);

  // Map a 12-bit position onto the window index range
  function automatic logic [AW-1:0] win_idx(input logic [POS_W-1:0] v);
    logic [AW+POS_W-1:0] w;
    w = {{AW{1'b0}}, v};
    return w[AW-1:0];
  endfunction

  back_state_t state, state_next;

  logic [7:0]    mem [WINDOW_SIZE];
  logic [7:0]    mem_q;
  logic [7:0]    last_wr;

  logic [AW-1:0] wp, blk_start, src;
  logic [AW:0]   fill;
  logic [LW-1:0] remain;
  logic          cp_end;

  logic land_v, land_hit, land_fwd, land_last, land_end;

  out_item_t        oq [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr, oq_rd;
  logic [OQ_CW-1:0] oq_cnt;

  logic          credit, issue, lit_take;
  logic          we, oq_push, oq_pop;
  logic [AW-1:0] waddr, off;
  logic [7:0]    wdata, land_data;
  out_item_t     push_item;
  logic          rd_hit, rd_fwd;

  // Handshake with the command queue and the result queue credit
  always_comb begin
    credit   = ((OQ_CW + 1)'(oq_cnt) + (OQ_CW + 1)'(land_v)) < (OQ_CW + 1)'(OQ_DEPTH);
    cmd_pop  = (state == B_IDLE) && !cmd_empty && !land_v && credit;
    lit_take = cmd_pop && (cmd.kind == CMD_LIT);
    issue    = (state == B_COPY) && credit;
  end

  // Next sequencer state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (cmd_pop && cmd.kind == CMD_COPY) state_next = B_COPY;
      B_COPY: if (issue && remain == LW'(1)) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Window write, read lookup and result push
  always_comb begin
    off       = src - blk_start;
    rd_hit    = ({1'b0, off} < fill);
    rd_fwd    = land_v && (src == wp);
    land_data = land_fwd ? last_wr : (land_hit ? mem_q : 8'h00);
    waddr     = wp;
    we        = 1'b0;
    wdata     = land_data;
    oq_push   = 1'b0;
    push_item = '{out_byte: land_data, run_last: land_last, block_end: land_end};
    unique case (state)
      B_IDLE: begin
        if (lit_take) begin
          we        = 1'b1;
          wdata     = cmd.arg[7:0];
          oq_push   = 1'b1;
          push_item = '{out_byte: cmd.arg[7:0], run_last: 1'b1, block_end: cmd.last_blk};
        end else if (land_v) begin
          we      = 1'b1;
          oq_push = 1'b1;
        end
      end
      B_COPY: begin
        we      = land_v;
        oq_push = land_v;
      end
      default: we = 1'b0;
    endcase
    oq_pop = pop && !empty;
  end

  // History window memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (issue) mem_q <= mem[src];
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // Write position, valid range and copy control
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= win_idx(START_POS_RST);
      blk_start <= win_idx(START_POS_RST);
      fill      <= '0;
      land_v    <= 1'b0;
    end else begin
      land_v <= issue;
      if (cmd_pop && cmd.kind == CMD_START) begin
        wp        <= win_idx(cmd.arg);
        blk_start <= win_idx(cmd.arg);
        fill      <= '0;
      end else if (we) begin
        wp <= wp + AW'(1);
        if (fill != WIN_FULL) fill <= fill + (AW + 1)'(1);
      end
    end
  end

  // Copy datapath
  always_ff @(posedge clk) begin
    if (we) last_wr <= wdata;
    if (cmd_pop && cmd.kind == CMD_COPY) begin
      src    <= win_idx(cmd.arg);
      remain <= LW'(cmd.len_code) + LW'(MIN_MATCH);
      cp_end <= cmd.last_blk;
    end else if (issue) begin
      src    <= src + AW'(1);
      remain <= remain - LW'(1);
    end
    if (issue) begin
      land_hit  <= rd_hit;
      land_fwd  <= rd_fwd;
      land_last <= (remain == LW'(1));
      land_end  <= cp_end && (remain == LW'(1));
    end
  end

  // Result queue
  always_comb begin
    empty    = (oq_cnt == '0);
    out_item = oq[oq_rd];
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq[oq_wr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= '0;
      oq_rd  <= '0;
      oq_cnt <= '0;
    end else begin
      if (oq_push) oq_wr <= oq_wr + OQ_AW'(1);
      if (oq_pop) oq_rd <= oq_rd + OQ_AW'(1);
      oq_cnt <= oq_cnt + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
    end
  end

  // A landing byte always finds room in the result queue
  a_land_room: assert property (@(posedge clk) disable iff (rst)
    land_v |-> (oq_cnt < OQ_CW'(OQ_DEPTH)))
    else $error("copy byte landed with full result queue");

  // A literal store never collides with a landing copy byte
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(lit_take && land_v))
    else $error("two window writes in one cycle");

  // The valid range never exceeds the window
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= WIN_FULL)
    else $error("window fill count overflow");

  // A running copy always has bytes left
  a_copy_len: assert property (@(posedge clk) disable iff (rst)
    (state == B_COPY) |-> (remain != '0))
    else $error("copy running with zero length");

  // The last byte of a copy returns the sequencer to idle
  a_copy_done: assert property (@(posedge clk) disable iff (rst)
    (issue && remain == LW'(1)) |=> (state == B_IDLE))
    else $error("copy did not finish on its last byte");

endmodule

// File: rtl/lzss_stream_decoder_unit.sv
// LZSS stream decoder with a history window of WINDOW_SIZE bytes.
//
// Input side is a queue: drive in_item and push; the item is taken on an edge
// where push is high and full is low. Each item is one byte of the packed
// stream; start_req marks the first header byte of a new block, which
// restarts decoding from any phase.
// Result side is a queue: while empty is low, out_item holds the oldest
// decoded byte; it is taken on an edge where pop is high.
// The start position register is written over cfg_valid/cfg_ready/cfg_data
// (cfg_ready is always high) and is used at the next block start.
// With the back part idle, a taken literal passes the command queue and then
// the result queue, both registered. A match token first loads the copy engine,
// then reads one byte per cycle, while the result queue has room, out of the
// window memory's single read port. Header, flag and token-high bytes give no result.
// A four-entry command queue lets bytes keep arriving while a copy runs.
// When the receiver stalls, the four-entry result queue fills, the copy
// engine pauses, and full rises once the command queue backs up.
// Reset empties both queues, idles the parser and treats the whole window as
// zero; a block start restores that view at once, with no clearing sweep.
// Depends on lsd_pkg, lsd_front, lsd_cmd_queue and lsd_back.
module lzss_stream_decoder_unit #(
  parameter int unsigned WINDOW_SIZE = 4096,
  parameter int unsigned MIN_MATCH   = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  lsd_pkg::in_item_t         in_item,
  output logic                      empty,
  input  logic                      pop,
  output lsd_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lsd_pkg::POS_W-1:0] cfg_data
);
  import lsd_pkg::*;

  logic [POS_W-1:0] start_pos;
  logic             accept;
  logic             cmd_push, cmd_pop, cmd_empty;
  cmd_t             cmd_in, cmd_head;

  // Start position register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) start_pos <= START_POS_RST;
    else if (cfg_valid && cfg_ready) start_pos <= cfg_data;
  end

  assign accept = push && !full;

  lsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_item),
    .start_pos (start_pos),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  lsd_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_cmd (cmd_in),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd_head),
    .empty  (cmd_empty)
  );

  lsd_back #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MIN_MATCH   (MIN_MATCH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// File: tb/tb_lzss_stream_decoder_unit.sv
// Self-checking testbench for lzss_stream_decoder_unit: a window-tracking
// decode model predicts every decoded byte, directed and random packed blocks.
// Depends on rtl/lsd_pkg.sv and the decoder RTL; reads no files.
module tb_lzss_stream_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lsd_pkg::*;

  localparam int unsigned WINDOW_BYTES   = 4096;
  localparam int unsigned MIN_RUN        = 3;
  localparam int          CLK_PERIOD     = 20;
  localparam int          RESET_CYCLES   = 11;
  localparam int          SETTLE_CYCLES  = 64;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          PHASE_ITEMS    = 36;
  localparam int          REPORT_CAP     = 25;

  // Decode model: own copy of the window and parser, plus decoded bytes in flight
  class lzss_decode_tracker;
    logic [7:0]          hist [WINDOW_BYTES];
    logic [POS_W-1:0]    wr_pos;
    logic [POS_W-1:0]    start_pos;
    logic [BUDGET_W-1:0] budget;
    logic [7:0]          flags;
    logic [7:0]          mask;
    logic [7:0]          tok_hi;
    front_phase_t        phase;
    out_item_t           awaited_bytes[$];
    int unsigned         mismatches;
    int unsigned         bytes_in;
    int unsigned         bytes_out;

    function new();
      foreach (hist[i]) hist[i] = 8'h00;
      start_pos  = START_POS_RST;
      wr_pos     = START_POS_RST;
      budget     = '0;
      flags      = '0;
      mask       = '0;
      tok_hi     = '0;
      phase      = PH_IDLE;
      mismatches = 0;
      bytes_in   = 0;
      bytes_out  = 0;
    endfunction

    function void set_start_position(logic [POS_W-1:0] p);
      start_pos = p;
    endfunction

    function void put_hist(logic [7:0] v);
      hist[wr_pos] = v;
      wr_pos = wr_pos + 1'b1;
    endfunction

    // Charge an item to the budget; returns 1 when the block closes
    function bit close_item(int cost);
      budget = (budget > cost) ? budget - BUDGET_W'(cost) : '0;
      mask = mask >> 1;
      if (budget == 0) begin
        phase = PH_IDLE;
        return 1'b1;
      end
      phase = PH_DATA;
      return 1'b0;
    endfunction

    // Accepted packed byte: advance the parser and queue the bytes it decodes to
    function void take_packed_byte(in_item_t it);
      logic [7:0]       b;
      logic [15:0]      w;
      logic [POS_W-1:0] src;
      logic [7:0]       v;
      int               cnt;
      bit               done;
      out_item_t        r;
      b = it.in_byte;
      bytes_in++;
      if (it.start_req) begin
        foreach (hist[i]) hist[i] = 8'h00;
        wr_pos = start_pos;
        budget = {1'b0, b, 8'h00};
        flags  = '0;
        mask   = '0;
        tok_hi = '0;
        phase  = PH_HDR_LO;
        return;
      end
      case (phase)
        PH_HDR_LO: begin
          budget = {1'b0, budget[15:8], b} + 17'd1;
          phase = PH_DATA;
        end
        PH_DATA: begin
          if (mask == 0) begin
            flags = b;
            mask = FLAG_MSB;
            budget = (budget > 1) ? budget - 1'b1 : '0;
          end else if ((flags & mask) != 0) begin
            put_hist(b);
            done = close_item(1);
            r.out_byte  = b;
            r.run_last  = 1'b1;
            r.block_end = done;
            awaited_bytes.push_back(r);
          end else begin
            tok_hi = b;
            phase = PH_TOK_LO;
          end
        end
        PH_TOK_LO: begin
          // copy byte by byte so overlapping matches repeat fresh bytes
          w = {tok_hi, b};
          src = w[15:4];
          cnt = int'(w[3:0]) + MIN_RUN;
          done = close_item(2);
          for (int k = 0; k < cnt; k++) begin
            v = hist[src];
            put_hist(v);
            src = src + 1'b1;
            r.out_byte  = v;
            r.run_last  = (k == cnt - 1);
            r.block_end = r.run_last & done;
            awaited_bytes.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_decoded(out_item_t got);
      out_item_t want;
      bytes_out++;
      if (awaited_bytes.size() == 0) begin
        report_mismatch($sformatf("decoded byte %02h with nothing outstanding",
                                  got.out_byte));
        return;
      end
      want = awaited_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out byte #%0d: out_byte %02h, want %02h",
                                  bytes_out, got.out_byte, want.out_byte));
      if (got.run_last !== want.run_last)
        report_mismatch($sformatf("out byte #%0d: run_last %b, want %b",
                                  bytes_out, got.run_last, want.run_last));
      if (got.block_end !== want.block_end)
        report_mismatch($sformatf("out byte #%0d: block_end %b, want %b",
                                  bytes_out, got.block_end, want.block_end));
    endtask
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               push      = 1'b0;
  logic               full;
  in_item_t           in_item   = '0;
  logic               empty;
  logic               pop       = 1'b0;
  out_item_t          out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [POS_W-1:0]   cfg_data  = '0;

  lzss_decode_tracker tracker;
  in_item_t           stim[$];
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;

  lzss_stream_decoder_unit #(
    .WINDOW_SIZE (WINDOW_BYTES),
    .MIN_MATCH   (MIN_RUN)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side: random pop, check each accepted item
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) tracker.check_decoded(out_item);
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long with no handshake on any port ends the run
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic in_item_t pk(logic [7:0] b, logic s);
    in_item_t it;
    it.in_byte   = b;
    it.start_req = s;
    return it;
  endfunction

  // Append one packed block; kind 7 skews the header, kind 8 truncates the body
  function automatic int append_block(int kind);
    in_item_t         body[$];
    int               cost;
    int               groups;
    int               nbits;
    int               written;
    int               back_dist;
    int               hdr;
    int               cut;
    logic [POS_W-1:0] wp;
    logic [POS_W-1:0] src;
    logic [7:0]       flag_byte;
    logic [3:0]       len;
    cost = 0;
    written = 0;
    wp = tracker.start_pos;
    groups = ($urandom_range(7) == 0) ? $urandom_range(4, 3) : $urandom_range(2, 1);
    for (int g = 0; g < groups; g++) begin
      flag_byte = 8'($urandom_range(255));
      nbits = (g == groups - 1) ? $urandom_range(8, 1) : 8;
      body.push_back(pk(flag_byte, 1'b0));
      cost++;
      for (int k = 7; k >= 8 - nbits; k--) begin
        if (flag_byte[k]) begin
          body.push_back(pk(8'($urandom_range(255)), 1'b0));
          cost++;
          wp = wp + 1'b1;
          written++;
        end else begin
          // mostly point back into bytes of this block, sometimes anywhere
          if (written > 0 && $urandom_range(3) != 0) begin
            back_dist = $urandom_range((written < 20) ? written : 20, 1);
            src = wp - POS_W'(back_dist);
          end else begin
            src = POS_W'($urandom_range(WINDOW_BYTES - 1));
          end
          len = ($urandom_range(3) == 0) ? 4'hf : 4'($urandom_range(15));
          body.push_back(pk(src[11:4], 1'b0));
          body.push_back(pk({src[3:0], len}, 1'b0));
          cost += 2;
          wp = wp + len + 12'(MIN_RUN);
          written += int'(len) + MIN_RUN;
        end
      end
    end
    hdr = cost - 1;
    if (kind == 7) hdr = hdr + int'($urandom_range(6)) - 3;
    if (hdr < 0) hdr = 0;
    if (kind == 8) begin
      cut = $urandom_range(body.size(), 1);
      while (body.size() > cut) void'(body.pop_back());
    end
    stim.push_back(pk(hdr[15:8], 1'b1));
    stim.push_back(pk(hdr[7:0], 1'b0));
    foreach (body[i]) stim.push_back(body[i]);
    return body.size() + 2;
  endfunction

  // Random stream: mostly well-formed blocks, some skewed, cut or stray bytes
  task automatic build_random_stream(input int quota);
    int counted;
    int kind;
    counted = 0;
    while (counted < quota) begin
      kind = $urandom_range(9);
      if (kind == 9) begin
        repeat ($urandom_range(3, 1)) stim.push_back(pk(8'($urandom_range(255)), 1'b0));
      end else begin
        counted += append_block(kind);
      end
    end
  endtask

  // Directed items: field extremes, aborts in every phase, budget corners, wrap
  task automatic load_directed();
    stim.push_back(pk(8'ha5, 1'b0));  // stray byte while idle
    stim.push_back(pk(8'hff, 1'b1));  // header 0xffff, largest budget
    stim.push_back(pk(8'hff, 1'b0));
    stim.push_back(pk(8'h00, 1'b0));  // flag byte, all tokens
    stim.push_back(pk(8'h00, 1'b1));  // start while decoding data
    stim.push_back(pk(8'h00, 1'b1));  // start while waiting for header low
    stim.push_back(pk(8'h00, 1'b0));  // budget 1
    stim.push_back(pk(8'hff, 1'b0));  // flag uses up the budget
    stim.push_back(pk(8'hff, 1'b0));  // literal still decoded, ends block
    stim.push_back(pk(8'h00, 1'b0));  // ignored after end
    stim.push_back(pk(8'h00, 1'b1));
    stim.push_back(pk(8'h06, 1'b0));  // budget 7
    stim.push_back(pk(8'h80, 1'b0));  // one literal then tokens
    stim.push_back(pk(8'hc3, 1'b0));
    stim.push_back(pk(8'hfe, 1'b0));  // overlapped 18-byte copy across the wrap
    stim.push_back(pk(8'hef, 1'b0));
    stim.push_back(pk(8'hff, 1'b0));  // source wraps from the top of the window
    stim.push_back(pk(8'hf0, 1'b0));
    stim.push_back(pk(8'h00, 1'b0));  // token with budget 1 saturates to zero
    stim.push_back(pk(8'h02, 1'b0));
    stim.push_back(pk(8'h00, 1'b1));
    stim.push_back(pk(8'h10, 1'b0));
    stim.push_back(pk(8'h00, 1'b0));
    stim.push_back(pk(8'h12, 1'b0));
    stim.push_back(pk(8'h34, 1'b1));  // start while waiting for token low
  endtask

  task automatic send_stream(input int idle_pct);
    in_item_t it;
    while (stim.size() != 0) begin
      it = stim.pop_front();
      while ($urandom_range(99) < idle_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push    <= 1'b1;
      in_item <= it;
      do @(posedge clk); while (full);
      tracker.take_packed_byte(it);
    end
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.awaited_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_position(input logic [POS_W-1:0] p);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_start_position(p);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [POS_W-1:0] p, input int idle_pct,
                           input int stall);
    write_start_position(p);
    stall_pct = stall;
    build_random_stream(PHASE_ITEMS);
    send_stream(idle_pct);
    wait_drained();
  endtask

  initial begin
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset start position, no idling
    load_directed();
    send_stream(0);
    wait_drained();

    // random phases: start position extremes, then idle and stall patterns
    run_phase(12'h000, 0, 0);
    run_phase(12'hfff, 87, 0);
    run_phase(POS_W'($urandom_range(WINDOW_BYTES - 1)), 0, 87);
    run_phase(START_POS_RST, 27, 27);

    if (tracker.awaited_bytes.size() != 0)
      tracker.report_mismatch($sformatf("%0d decoded bytes never arrived",
                                        tracker.awaited_bytes.size()));
    $display("Covered %0d packed bytes in and %0d decoded bytes out, %0d mismatches",
             tracker.bytes_in, tracker.bytes_out, tracker.mismatches);
    $display("Start positions: reset value, 0, 4095, one random; varied idle and stall");
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
